### hw/rtl/tlge_pkg.sv
package tlge_pkg;

  localparam int ROW_BITS = 64;
  localparam int IDX_BITS = 6;
  localparam int GEN_BITS = 32;
  localparam int CMD_BITS = 2;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [IDX_BITS-1:0] row_index;
    logic [ROW_BITS-1:0] row_cells;
  } in_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells_out;
    logic [GEN_BITS-1:0] generation_count;
  } out_item_t;

endpackage

### hw/rtl/toroidal_life_generation_engine.sv
// Channel  | Ports                          | Carries
// ---------+--------------------------------+---------------------------------------
// input    | in_valid, in_stall, in_data    | command, row index, row cells
// output   | out_valid, out_stall, out_data | row read back, generation count
//
// Every command makes one full turn of the ring before it presents its result:
// the grid rows circulate once around a ring of row cells, one row per cycle,
// and the head of the ring is where rows are written, read or advanced.
// Reset clears every cell and the generation count at once; no sweep is needed.
// A new command is taken while the result is held only if that result is
// transferred in the same cycle; out_stall holds the result register unchanged.
module toroidal_life_generation_engine #(
  parameter int GRID_CELLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlge_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlge_pkg::out_item_t  out_data
);

  localparam int CW = $clog2(GRID_CELLS);
  localparam int RB = tlge_pkg::ROW_BITS;
  localparam int IB = tlge_pkg::IDX_BITS;
  localparam int GB = tlge_pkg::GEN_BITS;

  tlge_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]            cmd_r;
  logic [IB-1:0]         idx_r;
  logic [GRID_CELLS-1:0] wdata_r;
  logic [GRID_CELLS-1:0] rd_r;
  logic [GRID_CELLS-1:0] prev_r;
  logic [GRID_CELLS-1:0] first_r;
  logic [GB-1:0]         gen_r;
  tlge_pkg::out_item_t   out_r;

  logic                  in_xfer;
  logic                  running;
  logic                  last;
  logic                  hit;
  logic [GRID_CELLS-1:0] row_q [GRID_CELLS];
  logic [GRID_CELLS-1:0] row_up;
  logic [GRID_CELLS-1:0] row_down;
  logic [GRID_CELLS-1:0] row_new;
  logic [GRID_CELLS-1:0] tail_in;
  logic [GB-1:0]         gen_nxt;

  assign in_xfer  = in_valid && !in_stall;
  assign running  = (state_r == tlge_pkg::ST_RUN);
  assign last     = (cnt_r == CW'(GRID_CELLS - 1));
  assign hit      = (IB'(cnt_r) == idx_r);

  // The ring of rows. Cell 0 is the head; each cycle of a command every row
  // moves one cell toward the head, and the head row re-enters at the tail,
  // possibly replaced. After a full turn every row is back in its own cell.
  for (genvar k = 0; k < GRID_CELLS; k++) begin : g_ring
    logic [GRID_CELLS-1:0] d;
    if (k == GRID_CELLS - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_body
      assign d = row_q[k+1];
    end
    tlge_cell #(.WIDTH(GRID_CELLS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (running),
      .d_in     (d),
      .q        (row_q[k])
    );
  end

  // Neighbor rows for the row at the head. On the first cycle the row above
  // row 0 is the last row, still in the tail cell. On the last cycle the row
  // below is old row 0, which was already replaced in the ring and is kept
  // in first_r.
  assign row_up   = (cnt_r == '0) ? row_q[GRID_CELLS-1] : prev_r;
  assign row_down = last ? first_r : row_q[1];

  tlge_rule #(.WIDTH(GRID_CELLS)) u_rule (
    .row_up   (row_up),
    .row_cur  (row_q[0]),
    .row_down (row_down),
    .row_next (row_new)
  );

  always_comb begin
    tail_in = row_q[0];
    case (cmd_r)
      tlge_pkg::CMD_WRITE: if (hit) tail_in = wdata_r;
      tlge_pkg::CMD_STEP:  tail_in = row_new;
      default:             tail_in = row_q[0];
    endcase
  end

  assign gen_nxt = (cmd_r == tlge_pkg::CMD_STEP) ? gen_r + GB'(1) : gen_r;

  // Sequencer: idle, one full ring turn, then hold the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlge_pkg::ST_IDLE;
      cnt_r   <= '0;
      gen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (running && last) begin
        gen_r <= gen_nxt;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      tlge_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = tlge_pkg::ST_RUN;
          cnt_nxt   = '0;
        end
      end
      tlge_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (last) begin
          state_nxt = tlge_pkg::ST_DONE;
          cnt_nxt   = '0;
        end
      end
      tlge_pkg::ST_DONE: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        if (!out_stall) begin
          state_nxt = in_valid ? tlge_pkg::ST_RUN : tlge_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = tlge_pkg::ST_IDLE;
      end
    endcase
  end

  // Command capture, head-side working rows and the result register.
  // A read of the last row reaches the head on the final cycle, so the
  // result then takes the head row directly.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_data.cmd;
      idx_r   <= in_data.row_index;
      wdata_r <= in_data.row_cells[GRID_CELLS-1:0];
      rd_r    <= '0;
    end else if (running) begin
      prev_r <= row_q[0];
      if (cnt_r == '0) begin
        first_r <= row_q[0];
      end
      if (cmd_r == tlge_pkg::CMD_READ && hit) begin
        rd_r <= row_q[0];
      end
    end
    if (running && last) begin
      out_r.row_cells_out    <= (cmd_r == tlge_pkg::CMD_READ && hit) ? RB'(row_q[0])
                                                                      : RB'(rd_r);
      out_r.generation_count <= gen_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### hw/rtl/tlge_cell.sv
module tlge_cell #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] row_r;

  // One grid row; the whole chain moves one place per enabled cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (shift_en) begin
      row_r <= d_in;
    end
  end

  assign q = row_r;

endmodule

### hw/rtl/tlge_rule.sv
module tlge_rule #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] row_up,
  input  logic [WIDTH-1:0] row_cur,
  input  logic [WIDTH-1:0] row_down,
  output logic [WIDTH-1:0] row_next
);

  for (genvar c = 0; c < WIDTH; c++) begin : g_col
    localparam int L = (c + WIDTH - 1) % WIDTH;
    localparam int R = (c + 1) % WIDTH;
    logic [3:0] n;

    assign n = 4'(row_up[L]) + 4'(row_up[c]) + 4'(row_up[R])
             + 4'(row_cur[L]) + 4'(row_cur[R])
             + 4'(row_down[L]) + 4'(row_down[c]) + 4'(row_down[R]);

    assign row_next[c] = row_cur[c]
                       ? (n == tlge_pkg::SURVIVE_LOW || n == tlge_pkg::BIRTH_COUNT)
                       : (n == tlge_pkg::BIRTH_COUNT);
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb #(
  parameter int GRID_CELLS = 64
);

  import tlge_pkg::*;

  // The unused command code changes nothing and still returns one result.
  localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

  // Shifting by the full width yields zero, so this is all ones for a 64 cell grid.
  localparam logic [ROW_BITS-1:0] ROW_MASK = (64'd1 << GRID_CELLS) - 64'd1;

  // A busy engine answers one command at a time, each after a full ring turn. The limit
  // allows for every command waiting out long sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 600000;

  // Tracks the grid and the generation count, and keeps one expected result per
  // accepted command in transfer order.
  class life_grid_tracker;
    bit [ROW_BITS-1:0] grid [GRID_CELLS];
    bit [GEN_BITS-1:0] gen_count;
    out_item_t         expected_results [$];
    int                mismatch_count;
    int                results_seen;

    function new();
      foreach (grid[r]) grid[r] = '0;
      gen_count      = '0;
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    // One generation of B3/S23 on the torus; all new rows come from the old grid.
    function void advance();
      bit [ROW_BITS-1:0] nxt [GRID_CELLS];
      bit [ROW_BITS-1:0] up, cur, dn;
      int                n, cl, cr;
      for (int r = 0; r < GRID_CELLS; r++) begin
        up     = grid[(r + GRID_CELLS - 1) % GRID_CELLS];
        cur    = grid[r];
        dn     = grid[(r + 1) % GRID_CELLS];
        nxt[r] = '0;
        for (int c = 0; c < GRID_CELLS; c++) begin
          cl = (c + GRID_CELLS - 1) % GRID_CELLS;
          cr = (c + 1) % GRID_CELLS;
          n  = up[cl] + up[c] + up[cr] + cur[cl] + cur[cr] + dn[cl] + dn[c] + dn[cr];
          if (cur[c] ? (n == SURVIVE_LOW || n == BIRTH_COUNT) : (n == BIRTH_COUNT)) begin
            nxt[r][c] = 1'b1;
          end
        end
      end
      foreach (grid[r]) grid[r] = nxt[r] & ROW_MASK;
      gen_count++;
    endfunction

    function void note_command(in_item_t item);
      out_item_t want;
      want = '0;
      case (item.cmd)
        CMD_WRITE: begin
          if (item.row_index < GRID_CELLS) grid[item.row_index] = item.row_cells & ROW_MASK;
        end
        CMD_STEP: begin
          advance();
        end
        CMD_READ: begin
          if (item.row_index < GRID_CELLS) want.row_cells_out = grid[item.row_index] & ROW_MASK;
        end
        default: begin
        end
      endcase
      want.generation_count = gen_count;
      expected_results.push_back(want);
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d arrived with nothing expected: row %h gen %0d",
                   results_seen, got.row_cells_out, got.generation_count);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.row_cells_out !== want.row_cells_out ||
          got.generation_count !== want.generation_count) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d mismatch: expected row %h gen %0d, got row %h gen %0d",
                   results_seen, want.row_cells_out, want.generation_count,
                   got.row_cells_out, got.generation_count);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  life_grid_tracker tracker;
  int               sender_idle_pct;
  int               recv_stall_pct;
  int               items_sent;
  int               cycle_count;

  toroidal_life_generation_engine #(
    .GRID_CELLS(GRID_CELLS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver decides at each falling edge whether to hold off the next
  // result transfer; the stall rate follows the current phase.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A result transfer happens at a rising edge with out_valid high and
  // out_stall low. Sampling here sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_row(out_data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one command from a falling edge and holds it until the engine
  // takes it. The payload never changes while the transfer is pending. The
  // task returns at the falling edge after the transfer, so a following call
  // can keep in_valid high with no gap.
  task automatic send_cmd(input logic [CMD_BITS-1:0] cmd, input logic [IDX_BITS-1:0] idx,
                          input logic [ROW_BITS-1:0] cells);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data.cmd       = cmd;
    in_data.row_index = idx;
    in_data.row_cells = cells;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_command(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits for every outstanding result to come back.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // One burst of random traffic. Most bursts build a small pattern (random
  // rows, sparse rows, a glider, solid or empty rows), let it evolve for a
  // few generations, and read the neighborhood back. The rest are random
  // reads and fully random commands, the unused code included.
  task automatic run_scene();
    int                kind, base, rows, shape, shift;
    logic [ROW_BITS-1:0] cells;
    kind  = $urandom_range(9);
    base  = $urandom_range(63);
    shift = $urandom_range(63);
    if (kind < 6) begin
      rows  = $urandom_range(1, 6);
      shape = $urandom_range(4);
      for (int i = 0; i < rows; i++) begin
        case (shape)
          0: cells = {$urandom, $urandom};
          1: cells = {$urandom, $urandom} & {$urandom, $urandom};
          2: begin
            cells = (i == 0) ? 64'h2 : (i == 1) ? 64'h4 : (i == 2) ? 64'h7 : 64'h0;
            cells = (cells << shift) | (cells >> (64 - shift));
          end
          3: cells = '1;
          default: cells = '0;
        endcase
        send_cmd(CMD_WRITE, IDX_BITS'(base + i), cells);
      end
      repeat ($urandom_range(1, 3)) send_cmd(CMD_STEP, IDX_BITS'($urandom), {$urandom, $urandom});
      repeat ($urandom_range(1, 5)) begin
        send_cmd(CMD_READ, IDX_BITS'(base + 63 + $urandom_range(7)), {$urandom, $urandom});
      end
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 4)) send_cmd(CMD_READ, IDX_BITS'($urandom), {$urandom, $urandom});
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_cmd(CMD_BITS'($urandom), IDX_BITS'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    int target;
    tracker         = new();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    cycle_count     = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: the cleared grid, the unused command, solid and empty
    // rows, both extreme row indexes, a row touching both wrap corners, and a
    // blinker that straddles the column wrap.
    send_cmd(CMD_READ, 6'd0, '0);
    send_cmd(CMD_NONE, 6'd63, '1);
    send_cmd(CMD_WRITE, 6'd63, '1);
    send_cmd(CMD_WRITE, 6'd0, '1);
    send_cmd(CMD_WRITE, IDX_BITS'(GRID_CELLS - 1), 64'h8000_0000_0000_0001);
    send_cmd(CMD_READ, 6'd63, '0);
    send_cmd(CMD_READ, 6'd0, '1);
    send_cmd(CMD_STEP, 6'd63, '1);
    send_cmd(CMD_READ, IDX_BITS'(GRID_CELLS - 1), '0);
    send_cmd(CMD_READ, 6'd0, '0);
    send_cmd(CMD_READ, 6'd1, '0);
    send_cmd(CMD_READ, IDX_BITS'(GRID_CELLS - 2), '0);
    send_cmd(CMD_WRITE, 6'd4, '0);
    send_cmd(CMD_WRITE, 6'd5, (64'd1 << (GRID_CELLS - 1)) | 64'd3);
    send_cmd(CMD_WRITE, 6'd6, '0);
    send_cmd(CMD_STEP, 6'd0, '0);
    send_cmd(CMD_READ, 6'd4, '0);
    send_cmd(CMD_READ, 6'd5, '0);
    send_cmd(CMD_READ, 6'd6, '0);
    send_cmd(CMD_STEP, 6'd0, '0);
    send_cmd(CMD_READ, 6'd5, '0);
    send_cmd(CMD_NONE, 6'd0, '0);

    // Let the engine empty out completely before the random traffic starts.
    wait_drained();

    // Random part in four phases: no idling, a sluggish sender, a sluggish
    // receiver, and light idling on both sides. Each phase drains at its end.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 56;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 56;
        end
        default: begin
          sender_idle_pct = 17;
          recv_stall_pct  = 17;
        end
      endcase
      target = items_sent + 200;
      while (items_sent < target) run_scene();
      wait_drained();
    end

    // Give a stray extra result time to show up before the verdict.
    repeat (2 * GRID_CELLS + 8) @(negedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tlge_pkg.sv
hw/rtl/tlge_cell.sv
hw/rtl/tlge_rule.sv
hw/rtl/toroidal_life_generation_engine.sv
dv/tb.sv
